### src/sait_pkg.sv
package sait_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int MAX_NAME   = 32;
    localparam int MAX_ATOMS  = TABLE_SIZE / 2;
    localparam int STRIDE_MOD = TABLE_SIZE - 3;

    localparam int SLOT_AW  = $clog2(TABLE_SIZE);
    localparam int ATOM_W   = 10;
    localparam int ENT_AW   = $clog2(MAX_ATOMS);
    localparam int BYTE_AW  = $clog2(MAX_NAME);
    localparam int NAME_AW  = ENT_AW + BYTE_AW;
    localparam int LEN_W    = BYTE_AW + 1;
    localparam int HASH_W   = 32;
    localparam int ENT_W    = HASH_W + LEN_W;
    localparam int KCNT_W   = LEN_W + 1;

    localparam logic [2:0] ST_FOUND   = 3'd0;
    localparam logic [2:0] ST_CREATED = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_LONG    = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;
    localparam logic [2:0] ST_NAME    = 3'd6;

    localparam logic OP_KEY   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_STRIDE,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_ENT_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_COPY_RD,
        S_COPY_WR,
        S_Q_LEN,
        S_Q_GET,
        S_Q_RD,
        S_Q_OUT
    } state_t;

    typedef struct packed {
        logic        operation;
        logic [7:0]  key_byte;
        logic        key_last;
        logic        make_new;
        logic [9:0]  query_atom;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  atom;
        logic [7:0]  name_byte;
        logic        name_last;
    } rsp_t;

endpackage

### src/sait_ram.sv
module sait_ram #(
    parameter int DW = 8,
    parameter int AW = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/string_atom_intern_table.sv
// channel | signals                 | handshake
// --------+-------------------------+--------------------------------------
// item in | req (req_t)             | taken when start=1 and busy=0
// result  | rsp (rsp_t)             | valid for one cycle while done=1
//
// Intermediate key bytes stay in S_IDLE. A final key byte runs the stride
// fold, then S_PROBE_RD/CHK and S_ENT_CHK per probe step, S_CMP_RD/CHK per
// compared name byte; creation adds S_COPY_RD/WR per byte copied. Name
// queries pass S_Q_LEN, S_Q_GET, then S_Q_RD/OUT per name byte; all set by
// one read port per table. After reset it is busy clearing the 1024 slots,
// one slot a cycle. The receiver cannot stall; one result per done cycle.
module string_atom_intern_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  sait_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output sait_pkg::rsp_t rsp
);
    import sait_pkg::*;

    state_t state_reg, state_next;

    logic [HASH_W-1:0]  rh_reg, rh_next;
    logic [KCNT_W-1:0]  kc_reg, kc_next;
    logic [ATOM_W-1:0]  hi_reg, hi_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               mk_reg, mk_next;
    logic [HASH_W-1:0]  fold_reg, fold_next;
    logic [SLOT_AW-1:0] slot_reg, slot_next;
    logic [SLOT_AW-1:0] stride_reg, stride_next;
    logic [SLOT_AW:0]   steps_reg, steps_next;
    logic [ATOM_W-1:0]  atom_reg, atom_next;
    logic [BYTE_AW-1:0] idx_reg, idx_next;
    logic [SLOT_AW:0]   clr_reg, clr_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    logic               accept;
    logic [HASH_W-1:0]  rh_shift;
    logic [HASH_W-1:0]  habs;
    logic [KCNT_W-1:0]  kc_inc;
    logic [HASH_W-1:0]  fold_step;
    logic               idx_end;
    logic [SLOT_AW:0]   slot_sum;
    logic [SLOT_AW-1:0] slot_adv;
    logic               probe_over;
    logic               can_make;
    logic [ATOM_W-1:0]  hi_inc;
    logic [ATOM_W-1:0]  atom_dec;
    logic [ATOM_W-1:0]  sd_dec;

    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [ATOM_W-1:0]  slot_wdata;
    logic [ATOM_W-1:0]  slot_rdata;
    logic               ent_we;
    logic [ENT_AW-1:0]  ent_raddr;
    logic [ENT_W-1:0]   ent_rdata;
    logic               name_we;
    logic [NAME_AW-1:0] name_waddr;
    logic [NAME_AW-1:0] name_raddr;
    logic [7:0]         name_rdata;
    logic               key_we;
    logic [7:0]         key_rdata;

    assign accept     = start && !busy;
    assign rh_shift   = {rh_reg[HASH_W-4:0], 3'b000} ^ {{(HASH_W-8){1'b0}}, req.key_byte};
    assign habs       = rh_shift[HASH_W-1] ? (~rh_shift + 32'd1) : rh_shift;
    assign kc_inc     = kc_reg + KCNT_W'(1);
    assign fold_step  = HASH_W'({fold_reg[HASH_W-1:SLOT_AW], 1'b0})
                      + HASH_W'(fold_reg[HASH_W-1:SLOT_AW])
                      + HASH_W'(fold_reg[SLOT_AW-1:0]);
    assign idx_end    = ({1'b0, idx_reg} == (len_reg - LEN_W'(1)));
    assign slot_sum   = {1'b0, slot_reg} + {1'b0, stride_reg};
    assign slot_adv   = slot_sum[SLOT_AW-1:0];
    assign probe_over = (steps_reg + (SLOT_AW+1)'(1)) == (SLOT_AW+1)'(TABLE_SIZE);
    assign can_make   = hi_reg < ATOM_W'(MAX_ATOMS);
    assign hi_inc     = hi_reg + ATOM_W'(1);
    assign atom_dec   = atom_reg - ATOM_W'(1);
    assign sd_dec     = slot_rdata - ATOM_W'(1);

    assign slot_we    = (state_reg == S_CLEAR) || ((state_reg == S_COPY_WR) && idx_end);
    assign slot_waddr = (state_reg == S_CLEAR) ? clr_reg[SLOT_AW-1:0] : slot_reg;
    assign slot_wdata = (state_reg == S_CLEAR) ? '0 : hi_inc;
    assign ent_we     = (state_reg == S_COPY_WR) && idx_end;
    assign ent_raddr  = (state_reg == S_PROBE_CHK) ? sd_dec[ENT_AW-1:0] : atom_dec[ENT_AW-1:0];
    assign name_we    = (state_reg == S_COPY_WR);
    assign name_waddr = {hi_reg[ENT_AW-1:0], idx_reg};
    assign name_raddr = {atom_dec[ENT_AW-1:0], idx_reg};
    assign key_we     = accept && (req.operation == OP_KEY) && (kc_reg < KCNT_W'(MAX_NAME));

    sait_ram #(.DW(ATOM_W), .AW(SLOT_AW)) u_slot (
        .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_reg), .rdata(slot_rdata)
    );

    sait_ram #(.DW(ENT_W), .AW(ENT_AW)) u_ent (
        .clk(clk), .we(ent_we), .waddr(hi_reg[ENT_AW-1:0]), .wdata({hash_reg, len_reg}),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    sait_ram #(.DW(8), .AW(NAME_AW)) u_name (
        .clk(clk), .we(name_we), .waddr(name_waddr), .wdata(key_rdata),
        .raddr(name_raddr), .rdata(name_rdata)
    );

    sait_ram #(.DW(8), .AW(BYTE_AW)) u_key (
        .clk(clk), .we(key_we), .waddr(kc_reg[BYTE_AW-1:0]), .wdata(req.key_byte),
        .raddr(idx_reg), .rdata(key_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == (SLOT_AW+1)'(TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.operation == OP_QUERY)
                    begin
                        if (req.query_atom != '0 && req.query_atom <= hi_reg)
                        begin
                            state_next = S_Q_LEN;
                        end
                    end
                    else if (req.key_last && kc_inc <= KCNT_W'(MAX_NAME))
                    begin
                        state_next = S_STRIDE;
                    end
                end
            end
            S_STRIDE:
            begin
                if (fold_reg < HASH_W'(TABLE_SIZE))
                begin
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD:
            begin
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                if (slot_rdata != '0)
                begin
                    state_next = S_ENT_CHK;
                end
                else if (mk_reg && can_make)
                begin
                    state_next = S_COPY_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ENT_CHK:
            begin
                if (ent_rdata == {hash_reg, len_reg})
                begin
                    state_next = S_CMP_RD;
                end
                else if (probe_over)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_PROBE_RD;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (name_rdata == key_rdata)
                begin
                    state_next = idx_end ? S_IDLE : S_CMP_RD;
                end
                else
                begin
                    state_next = probe_over ? S_IDLE : S_PROBE_RD;
                end
            end
            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                state_next = idx_end ? S_IDLE : S_COPY_RD;
            end
            S_Q_LEN:
            begin
                state_next = S_Q_GET;
            end
            S_Q_GET:
            begin
                state_next = S_Q_RD;
            end
            S_Q_RD:
            begin
                state_next = S_Q_OUT;
            end
            S_Q_OUT:
            begin
                state_next = idx_end ? S_IDLE : S_Q_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rh_next     = rh_reg;
        kc_next     = kc_reg;
        hi_next     = hi_reg;
        hash_next   = hash_reg;
        len_next    = len_reg;
        mk_next     = mk_reg;
        fold_next   = fold_reg;
        slot_next   = slot_reg;
        stride_next = stride_reg;
        steps_next  = steps_reg;
        atom_next   = atom_reg;
        idx_next    = idx_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        rsp_next    = '{status: ST_FOUND, atom: '0, name_byte: '0, name_last: 1'b1};
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + (SLOT_AW+1)'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.operation == OP_QUERY)
                    begin
                        atom_next = req.query_atom;
                        if (req.query_atom == '0 || req.query_atom > hi_reg)
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ST_INVALID;
                        end
                    end
                    else
                    begin
                        rh_next = rh_shift;
                        if (kc_reg <= KCNT_W'(MAX_NAME))
                        begin
                            kc_next = kc_inc;
                        end
                        if (req.key_last)
                        begin
                            rh_next   = '0;
                            kc_next   = '0;
                            hash_next = habs;
                            fold_next = habs;
                            len_next  = kc_inc[LEN_W-1:0];
                            mk_next   = req.make_new;
                            if (kc_inc > KCNT_W'(MAX_NAME))
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = ST_LONG;
                            end
                        end
                    end
                end
            end
            S_STRIDE:
            begin
                if (fold_reg >= HASH_W'(TABLE_SIZE))
                begin
                    fold_next = fold_step;
                end
                else
                begin
                    stride_next = (fold_reg >= HASH_W'(STRIDE_MOD))
                                ? SLOT_AW'(fold_reg - HASH_W'(STRIDE_MOD)) | SLOT_AW'(1)
                                : fold_reg[SLOT_AW-1:0] | SLOT_AW'(1);
                    slot_next   = hash_reg[SLOT_AW-1:0];
                    steps_next  = '0;
                end
            end
            S_PROBE_CHK:
            begin
                atom_next = slot_rdata;
                idx_next  = '0;
                if (slot_rdata == '0 && !(mk_reg && can_make))
                begin
                    done_next       = 1'b1;
                    rsp_next.status = mk_reg ? ST_FULL : ST_ABSENT;
                end
            end
            S_ENT_CHK:
            begin
                if (ent_rdata != {hash_reg, len_reg})
                begin
                    slot_next  = slot_adv;
                    steps_next = steps_reg + (SLOT_AW+1)'(1);
                    if (probe_over)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = mk_reg ? ST_FULL : ST_ABSENT;
                    end
                end
            end
            S_CMP_CHK:
            begin
                if (name_rdata == key_rdata)
                begin
                    idx_next = idx_reg + BYTE_AW'(1);
                    if (idx_end)
                    begin
                        done_next     = 1'b1;
                        rsp_next.atom = atom_reg;
                    end
                end
                else
                begin
                    slot_next  = slot_adv;
                    steps_next = steps_reg + (SLOT_AW+1)'(1);
                    if (probe_over)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = mk_reg ? ST_FULL : ST_ABSENT;
                    end
                end
            end
            S_COPY_WR:
            begin
                idx_next = idx_reg + BYTE_AW'(1);
                if (idx_end)
                begin
                    hi_next         = hi_inc;
                    done_next       = 1'b1;
                    rsp_next.status = ST_CREATED;
                    rsp_next.atom   = hi_inc;
                end
            end
            S_Q_GET:
            begin
                len_next = ent_rdata[LEN_W-1:0];
                idx_next = '0;
            end
            S_Q_OUT:
            begin
                idx_next           = idx_reg + BYTE_AW'(1);
                done_next          = 1'b1;
                rsp_next.status    = ST_NAME;
                rsp_next.atom      = atom_reg;
                rsp_next.name_byte = name_rdata;
                rsp_next.name_last = idx_end;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            rh_reg    <= '0;
            kc_reg    <= '0;
            hi_reg    <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rh_reg    <= rh_next;
            kc_reg    <= kc_next;
            hi_reg    <= hi_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg   <= hash_next;
        len_reg    <= len_next;
        mk_reg     <= mk_next;
        fold_reg   <= fold_next;
        slot_reg   <= slot_next;
        stride_reg <= stride_next;
        steps_reg  <= steps_next;
        atom_reg   <= atom_next;
        idx_reg    <= idx_next;
        rsp_reg    <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef NO_ASSERTIONS
    a_hi_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hi_reg <= ATOM_W'(MAX_ATOMS))
        else $error("atom count beyond table limit");
    a_created_atom: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == ST_CREATED |-> rsp.atom == hi_reg)
        else $error("created atom differs from highest atom");
    a_hi_step: assert property (@(posedge clk) disable iff (!rst_n)
        hi_reg != $past(hi_reg) |-> done && rsp.status == ST_CREATED)
        else $error("atom count moved without a create");
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_NAME |-> rsp.name_last)
        else $error("non-name result without last mark");
`endif

endmodule

### dv/intern_checker.sv
module intern_checker
    import sait_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  logic   busy,
    input  req_t   req,
    input  logic   done,
    input  rsp_t   rsp,
    output int     fail_count,
    output int     pending
);

    logic [9:0]  slot_map [TABLE_SIZE];
    logic [31:0] atom_hash [MAX_ATOMS];
    int          atom_len [MAX_ATOMS];
    logic [7:0]  atom_name [MAX_ATOMS][MAX_NAME];
    logic [7:0]  key_bytes [MAX_NAME];
    logic [31:0] hash_acc;
    int          key_len;
    int          atom_top;
    rsp_t        expected_q [$];
    int          created_count;
    int          found_count;
    int          name_items;

    function automatic rsp_t mk(logic [2:0] st, logic [9:0] a, logic [7:0] b,
                                logic l);
        rsp_t r;
        r.status = st;
        r.atom = a;
        r.name_byte = b;
        r.name_last = l;
        return r;
    endfunction

    function automatic bit same_key(int a, logic [31:0] h, int n);
        if (a == 0 || a > atom_top)
            return 1'b0;
        if (atom_hash[a-1] != h || atom_len[a-1] != n)
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (atom_name[a-1][i] != key_bytes[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic intern_item(req_t it);
        logic [31:0] h;
        int          n, slot, stride, a;
        bit          empty_seen;
        bit          hit;
        if (it.operation == OP_QUERY) begin
            a = int'(it.query_atom);
            if (a == 0 || a > atom_top || atom_len[a-1] == 0) begin
                expected_q.push_back(mk(ST_INVALID, 10'd0, 8'd0, 1'b1));
                return;
            end
            name_items++;
            for (int i = 0; i < atom_len[a-1]; i++)
                expected_q.push_back(mk(ST_NAME, 10'(a), atom_name[a-1][i],
                                        i == atom_len[a-1] - 1));
            return;
        end
        hash_acc = (hash_acc << 3) ^ {24'd0, it.key_byte};
        if (key_len < MAX_NAME)
            key_bytes[key_len] = it.key_byte;
        if (key_len <= MAX_NAME)
            key_len++;
        if (!it.key_last)
            return;
        h = hash_acc;
        if (h[31])
            h = -h;
        n = key_len;
        hash_acc = '0;
        key_len = 0;
        if (n > MAX_NAME) begin
            expected_q.push_back(mk(ST_LONG, 10'd0, 8'd0, 1'b1));
            return;
        end
        slot = int'(h % TABLE_SIZE);
        stride = int'((h % STRIDE_MOD) | 1);
        empty_seen = 0;
        hit = 0;
        for (int s = 0; s < TABLE_SIZE && !empty_seen && !hit; s++) begin
            a = int'(slot_map[slot]);
            if (a == 0)
                empty_seen = 1;
            else if (same_key(a, h, n))
                hit = 1;
            else begin
                slot += stride;
                if (slot >= TABLE_SIZE)
                    slot -= TABLE_SIZE;
            end
        end
        if (hit) begin
            found_count++;
            expected_q.push_back(mk(ST_FOUND, 10'(a), 8'd0, 1'b1));
        end else if (!it.make_new)
            expected_q.push_back(mk(ST_ABSENT, 10'd0, 8'd0, 1'b1));
        else if (atom_top >= MAX_ATOMS || !empty_seen)
            expected_q.push_back(mk(ST_FULL, 10'd0, 8'd0, 1'b1));
        else begin
            atom_top++;
            atom_hash[atom_top-1] = h;
            atom_len[atom_top-1] = n;
            for (int i = 0; i < n; i++)
                atom_name[atom_top-1][i] = key_bytes[i];
            slot_map[slot] = 10'(atom_top);
            created_count++;
            expected_q.push_back(mk(ST_CREATED, 10'(atom_top), 8'd0, 1'b1));
        end
    endtask

    initial
    begin
        foreach (slot_map[i])
            slot_map[i] = '0;
        hash_acc = '0;
        key_len = 0;
        atom_top = 0;
        fail_count = 0;
        pending = 0;
        created_count = 0;
        found_count = 0;
        name_items = 0;
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n) begin
            if (done) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", rsp);
                end else begin
                    want = expected_q.pop_front();
                    if (rsp !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp st=%0d atom=%0d byte=%h last=%b, got st=%0d atom=%0d byte=%h last=%b",
                                     want.status, want.atom, want.name_byte, want.name_last,
                                     rsp.status, rsp.atom, rsp.name_byte, rsp.name_last);
                    end
                end
            end
            if (start && !busy)
                intern_item(req);
            pending <= expected_q.size();
        end
    end

endmodule

### dv/testbench.sv
module testbench;
    import sait_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    int   cycles;
    byte  words [8][$];

    string_atom_intern_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    intern_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send(logic op, logic [7:0] b, logic l, logic mk, logic [9:0] q);
        req_t r;
        int   gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            start <= 0;
            req <= req_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        r.operation = op;
        r.key_byte = b;
        r.key_last = l;
        r.make_new = mk;
        r.query_atom = q;
        start <= 1;
        req <= r;
        do @(posedge clk); while (busy);
    endtask

    task automatic send_key(byte k [$], logic mk);
        for (int i = 0; i < k.size(); i++)
            send(OP_KEY, k[i], i == k.size() - 1, mk, 10'($urandom));
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    initial
    begin
        byte k [$];
        int  n;
        cycles = 0;
        start = 0;
        req = '0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed
        send(OP_QUERY, 8'd0, 1'b0, 1'b0, 10'd0);
        send(OP_QUERY, 8'd0, 1'b0, 1'b0, 10'd1);
        send_key('{8'h00}, 1'b0);
        send_key('{8'h00}, 1'b1);
        send_key('{8'h00}, 1'b1);
        send_key('{8'hff, 8'h80, 8'h7f}, 1'b1);
        send_key('{8'hff, 8'h80, 8'h7f}, 1'b0);
        send(OP_QUERY, 8'd0, 1'b0, 1'b0, 10'd2);
        send(OP_QUERY, 8'd0, 1'b0, 1'b0, 10'd3);
        send(OP_QUERY, 8'd0, 1'b0, 1'b0, 10'h3ff);
        send(OP_QUERY, 8'd0, 1'b0, 1'b0, 10'd512);
        // 0x80000000 hash: byte 0x02 then ten zeros shifts it to bit 31
        send_key('{8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
        k = {};
        repeat (MAX_NAME) k.push_back(byte'($urandom));
        send_key(k, 1'b1);
        k.push_back(8'h55);
        send_key(k, 1'b1);
        k = {};
        repeat (MAX_NAME + 5) k.push_back(byte'($urandom));
        send_key(k, 1'b0);
        // query mid-key
        send(OP_KEY, 8'h41, 1'b0, 1'b0, 10'd0);
        send(OP_QUERY, 8'd0, 1'b0, 1'b0, 10'd1);
        send(OP_KEY, 8'h42, 1'b1, 1'b1, 10'd0);
        drain();
        foreach (words[i])
        begin
            words[i] = {};
            n = $urandom_range(1, 6);
            repeat (n) words[i].push_back(byte'($urandom));
        end
        for (int it = 0; it < 30; it++)
        begin
            n = $urandom_range(0, 9);
            if (n < 4)
                send_key(words[$urandom_range(0, 7)], 1'($urandom));
            else if (n < 7)
                send(OP_QUERY, 8'd0, 1'b0, 1'b0, 10'($urandom_range(0, 40)));
            else if (n < 8)
                send(OP_QUERY, 8'd0, 1'b0, 1'b0, 10'($urandom));
            else begin
                k = {};
                repeat ($urandom_range(1, n == 9 ? 36 : 5)) k.push_back(byte'($urandom));
                send_key(k, 1'($urandom));
            end
            if (it == 15)
                drain();
        end
        drain();
        $display("covered %0d atoms created, %0d hits, %0d name queries",
                 u_chk.created_count, u_chk.found_count, u_chk.name_items);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
